// File: hw/rtl/cdax_pkg.sv
// Shared types and constants for the complex dot / axpy streaming block.
`default_nettype none

package cdax_pkg;

    // Default component width and fixed field widths
    localparam int COMPONENT_WIDTH_DEF = 32;
    localparam int FRAC_BITS           = 16;
    localparam int FIELD_W             = 32;
    localparam int ACC_W               = 64;
    localparam int CFG_INDEX_W         = 3;
    localparam int CFG_DATA_W          = 32;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHA_REAL  = 3'd0,
        REG_ALPHA_IMAG  = 3'd1,
        REG_CONJ_X_AXPY = 3'd2,
        REG_CONJ_X_DOT  = 3'd3,
        REG_CONJ_Y_DOT  = 3'd4
    } cfg_reg_t;

    // Conjugation controls
    typedef struct packed {
        logic conj_x_axpy;
        logic conj_x_dot;
        logic conj_y_dot;
    } cfg_flags_t;

    // Input beat: one element of x, y and z
    typedef struct packed {
        logic signed [FIELD_W-1:0] x_re;
        logic signed [FIELD_W-1:0] x_im;
        logic signed [FIELD_W-1:0] y_re;
        logic signed [FIELD_W-1:0] y_im;
        logic signed [FIELD_W-1:0] z_re;
        logic signed [FIELD_W-1:0] z_im;
        logic                      last_in;
    } in_beat_t;

    // Result beat: updated z and, on the last element, the dot product
    typedef struct packed {
        logic signed [FIELD_W-1:0] z_new_re;
        logic signed [FIELD_W-1:0] z_new_im;
        logic signed [ACC_W-1:0]   rho_re;
        logic signed [ACC_W-1:0]   rho_im;
        logic                      rho_valid;
    } out_beat_t;

endpackage

`default_nettype wire

// File: hw/rtl/cdax_mult.sv
// Multiply stage: the eight component products of one element, registered.
`default_nettype none

module cdax_mult #(
    parameter int COMPONENT_WIDTH = cdax_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  cdax_pkg::in_beat_t                  beat,
    input  logic signed [COMPONENT_WIDTH-1:0]   alpha_re,
    input  logic signed [COMPONENT_WIDTH-1:0]   alpha_im,
    output logic signed [2*COMPONENT_WIDTH-1:0] p_ar_xr_reg,
    output logic signed [2*COMPONENT_WIDTH-1:0] p_ai_xi_reg,
    output logic signed [2*COMPONENT_WIDTH-1:0] p_ai_xr_reg,
    output logic signed [2*COMPONENT_WIDTH-1:0] p_ar_xi_reg,
    output logic signed [2*COMPONENT_WIDTH-1:0] p_xr_yr_reg,
    output logic signed [2*COMPONENT_WIDTH-1:0] p_xi_yi_reg,
    output logic signed [2*COMPONENT_WIDTH-1:0] p_xr_yi_reg,
    output logic signed [2*COMPONENT_WIDTH-1:0] p_xi_yr_reg,
    output logic signed [COMPONENT_WIDTH-1:0]   z_re_reg,
    output logic signed [COMPONENT_WIDTH-1:0]   z_im_reg,
    output logic                                last_reg
);
    import cdax_pkg::*;

    localparam int W = COMPONENT_WIDTH;

    logic signed [W-1:0] xr;
    logic signed [W-1:0] xi;
    logic signed [W-1:0] yr;
    logic signed [W-1:0] yi;

    // Components live in the low bits of each field
    assign xr = beat.x_re[W-1:0];
    assign xi = beat.x_im[W-1:0];
    assign yr = beat.y_re[W-1:0];
    assign yi = beat.y_im[W-1:0];

    // Products: four for the z update, four for the dot term
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ar_xr_reg <= alpha_re * xr;
            p_ai_xi_reg <= alpha_im * xi;
            p_ai_xr_reg <= alpha_im * xr;
            p_ar_xi_reg <= alpha_re * xi;
            p_xr_yr_reg <= xr * yr;
            p_xi_yi_reg <= xi * yi;
            p_xr_yi_reg <= xr * yi;
            p_xi_yr_reg <= xi * yr;
            z_re_reg    <= beat.z_re[W-1:0];
            z_im_reg    <= beat.z_im[W-1:0];
            last_reg    <= beat.last_in;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cdax_combine.sv
// Combine stage: truncated z update with saturation, dot accumulation, result register.
`default_nettype none

module cdax_combine #(
    parameter int COMPONENT_WIDTH = cdax_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  cdax_pkg::cfg_flags_t                flags,
    input  logic signed [2*COMPONENT_WIDTH-1:0] p_ar_xr,
    input  logic signed [2*COMPONENT_WIDTH-1:0] p_ai_xi,
    input  logic signed [2*COMPONENT_WIDTH-1:0] p_ai_xr,
    input  logic signed [2*COMPONENT_WIDTH-1:0] p_ar_xi,
    input  logic signed [2*COMPONENT_WIDTH-1:0] p_xr_yr,
    input  logic signed [2*COMPONENT_WIDTH-1:0] p_xi_yi,
    input  logic signed [2*COMPONENT_WIDTH-1:0] p_xr_yi,
    input  logic signed [2*COMPONENT_WIDTH-1:0] p_xi_yr,
    input  logic signed [COMPONENT_WIDTH-1:0]   z_re,
    input  logic signed [COMPONENT_WIDTH-1:0]   z_im,
    input  logic                                last,
    output cdax_pkg::out_beat_t                 result_reg
);
    import cdax_pkg::*;

    localparam int W  = COMPONENT_WIDTH;
    localparam int TW = 2 * W - FRAC_BITS;   // truncated product width
    localparam int SW = TW + 2;              // z plus two products
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [TW-1:0]    t_rr;
    logic signed [TW-1:0]    t_ii;
    logic signed [TW-1:0]    t_ir;
    logic signed [TW-1:0]    t_ri;
    logic signed [SW-1:0]    nr;
    logic signed [SW-1:0]    ni;
    logic signed [W-1:0]     sat_re;
    logic signed [W-1:0]     sat_im;
    logic signed [ACC_W-1:0] e_rr;
    logic signed [ACC_W-1:0] e_ii;
    logic signed [ACC_W-1:0] e_ri;
    logic signed [ACC_W-1:0] e_ir;
    logic signed [ACC_W-1:0] sum_re;
    logic signed [ACC_W-1:0] sum_im;
    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;
    logic signed [ACC_W-1:0] acc_re_next;
    logic signed [ACC_W-1:0] acc_im_next;
    out_beat_t               result_next;

    // Drop fraction bits: floor toward minus infinity
    assign t_rr = p_ar_xr[2*W-1:FRAC_BITS];
    assign t_ii = p_ai_xi[2*W-1:FRAC_BITS];
    assign t_ir = p_ai_xr[2*W-1:FRAC_BITS];
    assign t_ri = p_ar_xi[2*W-1:FRAC_BITS];

    // z + alpha * x, x conjugated on request
    always_comb
    begin
        if (flags.conj_x_axpy)
        begin
            nr = SW'(z_re) + SW'(t_rr) + SW'(t_ii);
            ni = SW'(z_im) + SW'(t_ir) - SW'(t_ri);
        end
        else
        begin
            nr = SW'(z_re) + SW'(t_rr) - SW'(t_ii);
            ni = SW'(z_im) + SW'(t_ir) + SW'(t_ri);
        end
    end

    // Saturate to the component range
    always_comb
    begin
        if (nr > SAT_HI)
            sat_re = W'(SAT_HI);
        else if (nr < SAT_LO)
            sat_re = W'(SAT_LO);
        else
            sat_re = W'(nr);

        if (ni > SAT_HI)
            sat_im = W'(SAT_HI);
        else if (ni < SAT_LO)
            sat_im = W'(SAT_LO);
        else
            sat_im = W'(ni);
    end

    // Dot term, added modulo 2^64
    assign e_rr = ACC_W'(p_xr_yr);
    assign e_ii = ACC_W'(p_xi_yi);
    assign e_ri = ACC_W'(p_xr_yi);
    assign e_ir = ACC_W'(p_xi_yr);

    always_comb
    begin
        if (flags.conj_x_dot ^ flags.conj_y_dot)
            sum_re = acc_re_reg + e_rr + e_ii;
        else
            sum_re = acc_re_reg + e_rr - e_ii;

        sum_im = acc_im_reg + (flags.conj_y_dot ? -e_ri : e_ri)
                            + (flags.conj_x_dot ? -e_ir : e_ir);
    end

    // Next result and accumulator; last element flushes the sum
    always_comb
    begin
        result_next          = result_reg;
        acc_re_next          = acc_re_reg;
        acc_im_next          = acc_im_reg;
        if (en)
        begin
            result_next.z_new_re = FIELD_W'(sat_re);
            result_next.z_new_im = FIELD_W'(sat_im);
            if (last)
            begin
                result_next.rho_re    = sum_re;
                result_next.rho_im    = sum_im;
                result_next.rho_valid = 1'b1;
                acc_re_next           = '0;
                acc_im_next           = '0;
            end
            else
            begin
                result_next.rho_re    = '0;
                result_next.rho_im    = '0;
                result_next.rho_valid = 1'b0;
                acc_re_next           = sum_re;
                acc_im_next           = sum_im;
            end
        end
    end

    // Accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/complex_dot_axpy_stream.sv
// Streaming complex dot product and axpy: top level with config, input stage and flow control.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one x, y, z element per beat;
//   result channel (result_valid/result_ready/result) returns one beat per item,
//   z_new = z + alpha * x (x optionally conjugated), saturated to the component range.
//   The beat marked last_in also carries rho, the dot product of the whole vector
//   including that element, with rho_valid set; the accumulator then restarts at zero.
//   Configuration (alpha, conjugation flags) is written through cfg_we/cfg_index/cfg_data
//   by the user while no item is in flight, unchecked by the block; other indexes are ignored.
// Timing:
//   Three register stages (input, products, result); a beat passes through them in
//   that order. One beat per cycle sustained while result_ready stays high; the figure
//   is set by the single product stage, eight multipliers working in parallel.
// Reset clears configuration, accumulators and all stage valids.
// Stalls: each stage holds while the one after it is full and stalled, so empty
//   stages keep accepting beats until all three are occupied.
`default_nettype none

module complex_dot_axpy_stream #(
    parameter int COMPONENT_WIDTH = cdax_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cdax_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cdax_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  cdax_pkg::in_beat_t                  item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output cdax_pkg::out_beat_t                 result
);
    import cdax_pkg::*;

    localparam int W = COMPONENT_WIDTH;

    logic signed [W-1:0]     alpha_re_reg;
    logic signed [W-1:0]     alpha_im_reg;
    cfg_flags_t              flags_reg;
    in_beat_t                beat_a_reg;
    logic                    va_reg;
    logic                    vb_reg;
    logic                    vc_reg;
    logic                    va_next;
    logic                    vb_next;
    logic                    vc_next;
    logic                    load_a;
    logic                    load_b;
    logic                    load_c;

    logic signed [2*W-1:0]   p_ar_xr;
    logic signed [2*W-1:0]   p_ai_xi;
    logic signed [2*W-1:0]   p_ai_xr;
    logic signed [2*W-1:0]   p_ar_xi;
    logic signed [2*W-1:0]   p_xr_yr;
    logic signed [2*W-1:0]   p_xi_yi;
    logic signed [2*W-1:0]   p_xr_yi;
    logic signed [2*W-1:0]   p_xi_yr;
    logic signed [W-1:0]     z_re_b;
    logic signed [W-1:0]     z_im_b;
    logic                    last_b;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_re_reg <= '0;
            alpha_im_reg <= '0;
            flags_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ALPHA_REAL:  alpha_re_reg          <= cfg_data[W-1:0];
                REG_ALPHA_IMAG:  alpha_im_reg          <= cfg_data[W-1:0];
                REG_CONJ_X_AXPY: flags_reg.conj_x_axpy <= cfg_data[0];
                REG_CONJ_X_DOT:  flags_reg.conj_x_dot  <= cfg_data[0];
                REG_CONJ_Y_DOT:  flags_reg.conj_y_dot  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when its successor loads
    assign load_c     = !vc_reg || result_ready;
    assign load_b     = !vb_reg || load_c;
    assign load_a     = !va_reg || load_b;
    assign item_ready = load_a;

    assign va_next = load_a ? item_valid : va_reg;
    assign vb_next = load_b ? va_reg     : vb_reg;
    assign vc_next = load_c ? vb_reg     : vc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (load_a && item_valid)
            beat_a_reg <= item;
    end

    // Product stage
    cdax_mult #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_mult (
        .clk         (clk),
        .en          (load_b && va_reg),
        .beat        (beat_a_reg),
        .alpha_re    (alpha_re_reg),
        .alpha_im    (alpha_im_reg),
        .p_ar_xr_reg (p_ar_xr),
        .p_ai_xi_reg (p_ai_xi),
        .p_ai_xr_reg (p_ai_xr),
        .p_ar_xi_reg (p_ar_xi),
        .p_xr_yr_reg (p_xr_yr),
        .p_xi_yi_reg (p_xi_yi),
        .p_xr_yi_reg (p_xr_yi),
        .p_xi_yr_reg (p_xi_yr),
        .z_re_reg    (z_re_b),
        .z_im_reg    (z_im_b),
        .last_reg    (last_b)
    );

    // Sum, saturate, accumulate, result register
    cdax_combine #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_combine (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (load_c && vb_reg),
        .flags      (flags_reg),
        .p_ar_xr    (p_ar_xr),
        .p_ai_xi    (p_ai_xi),
        .p_ai_xr    (p_ai_xr),
        .p_ar_xi    (p_ar_xi),
        .p_xr_yr    (p_xr_yr),
        .p_xi_yi    (p_xi_yi),
        .p_xr_yi    (p_xr_yi),
        .p_xi_yr    (p_xi_yr),
        .z_re       (z_re_b),
        .z_im       (z_im_b),
        .last       (last_b),
        .result_reg (result)
    );

    assign result_valid = vc_reg;

endmodule

`default_nettype wire

// File: test/complex_dot_axpy_stream_checker.sv
// Checker for the complex dot / axpy stream: predicts every result beat and compares it.
`timescale 1ns / 1ps

module complex_dot_axpy_stream_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cdax_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cdax_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    input  logic                             item_ready,
    input  cdax_pkg::in_beat_t               item,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  cdax_pkg::out_beat_t              result,
    output int                               pending_count,
    output int                               fail_count,
    output int                               element_count,
    output int                               vector_count
);
    import cdax_pkg::*;

    localparam longint COMP_MAX = 64'sd2147483647;
    localparam longint COMP_MIN = -64'sd2147483648;
    localparam int     SHOWN_MISMATCHES = 10;

    // Shadow of the register file
    logic signed [FIELD_W-1:0] alpha_re;
    logic signed [FIELD_W-1:0] alpha_im;
    cfg_flags_t                flags;

    // Running dot product, Q32.32, wraps mod 2^64
    longint dot_re;
    longint dot_im;

    out_beat_t pending_results[$];
    int        mismatch_count;
    int        orphan_count;
    int        results_seen;
    int        elements_in;
    int        vectors_done;

    assign fail_count    = mismatch_count + orphan_count;
    assign element_count = elements_in;
    assign vector_count  = vectors_done;

    // Saturate an exact sum to the signed component range
    function automatic logic [FIELD_W-1:0] clamp_component(input longint v);
        if (v > COMP_MAX)
            return COMP_MAX[FIELD_W-1:0];
        if (v < COMP_MIN)
            return COMP_MIN[FIELD_W-1:0];
        return v[FIELD_W-1:0];
    endfunction

    // Expected result beat for one element; advances the dot product
    function automatic out_beat_t predict_element(input in_beat_t b);
        longint    xr, xi, yr, yi, zr, zi, ar, ai;
        longint    t_rr, t_ii, t_ir, t_ri, nr, ni;
        out_beat_t r;
        xr = longint'($signed(b.x_re));
        xi = longint'($signed(b.x_im));
        yr = longint'($signed(b.y_re));
        yi = longint'($signed(b.y_im));
        zr = longint'($signed(b.z_re));
        zi = longint'($signed(b.z_im));
        ar = longint'(alpha_re);
        ai = longint'(alpha_im);

        // alpha * x, each product floored to Q16.16
        t_rr = (ar * xr) >>> FRAC_BITS;
        t_ii = (ai * xi) >>> FRAC_BITS;
        t_ir = (ai * xr) >>> FRAC_BITS;
        t_ri = (ar * xi) >>> FRAC_BITS;
        if (flags.conj_x_axpy)
        begin
            nr = zr + t_rr + t_ii;
            ni = zi + t_ir - t_ri;
        end
        else
        begin
            nr = zr + t_rr - t_ii;
            ni = zi + t_ir + t_ri;
        end

        // dot product term, exact Q32.32
        dot_re += xr * yr;
        if (flags.conj_x_dot != flags.conj_y_dot)
            dot_re += xi * yi;
        else
            dot_re -= xi * yi;
        if (flags.conj_y_dot)
            dot_im -= xr * yi;
        else
            dot_im += xr * yi;
        if (flags.conj_x_dot)
            dot_im -= xi * yr;
        else
            dot_im += xi * yr;

        r.z_new_re  = clamp_component(nr);
        r.z_new_im  = clamp_component(ni);
        r.rho_re    = '0;
        r.rho_im    = '0;
        r.rho_valid = 1'b0;
        if (b.last_in)
        begin
            r.rho_re    = dot_re;
            r.rho_im    = dot_im;
            r.rho_valid = 1'b1;
            dot_re      = 0;
            dot_im      = 0;
        end
        return r;
    endfunction

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES)
                $display("%0t: result %0d %s mismatch: expected %h, got %h",
                         $realtime, results_seen, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            alpha_re = '0;
            alpha_im = '0;
            flags    = '0;
            dot_re   = 0;
            dot_im   = 0;
            pending_results.delete();
            mismatch_count = 0;
            orphan_count   = 0;
            results_seen   = 0;
            elements_in    = 0;
            vectors_done   = 0;
            pending_count <= 0;
        end
        else
        begin
            // input beat: predict with the settings in force before this edge
            if (item_valid && item_ready)
            begin
                pending_results.push_back(predict_element(item));
                elements_in++;
                if (item.last_in)
                    vectors_done++;
            end

            // result beat: compare with the oldest prediction
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    orphan_count++;
                    if (fail_count < SHOWN_MISMATCHES)
                        $display("%0t: result beat with nothing outstanding", $realtime);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("z_new_re", 64'(want.z_new_re), 64'(result.z_new_re));
                    check_field("z_new_im", 64'(want.z_new_im), 64'(result.z_new_im));
                    check_field("rho_re", want.rho_re, result.rho_re);
                    check_field("rho_im", want.rho_im, result.rho_im);
                    check_field("rho_valid", 64'(want.rho_valid), 64'(result.rho_valid));
                end
                results_seen++;
            end

            // register writes take effect for later beats
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA_REAL:  alpha_re          = cfg_data[FIELD_W-1:0];
                    REG_ALPHA_IMAG:  alpha_im          = cfg_data[FIELD_W-1:0];
                    REG_CONJ_X_AXPY: flags.conj_x_axpy = cfg_data[0];
                    REG_CONJ_X_DOT:  flags.conj_x_dot  = cfg_data[0];
                    REG_CONJ_Y_DOT:  flags.conj_y_dot  = cfg_data[0];
                    default: ;
                endcase
            end

            pending_count <= pending_results.size();
        end
    end

endmodule

// File: test/complex_dot_axpy_stream_test.sv
// Testbench top for the complex dot / axpy stream: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module complex_dot_axpy_stream_test;
    import cdax_pkg::*;

    localparam logic [FIELD_W-1:0]     Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0]     Q_MIN   = 32'h8000_0000;
    localparam logic [FIELD_W-1:0]     Q_ONE   = 32'h0001_0000;
    localparam logic [FIELD_W-1:0]     Q_ZERO  = 32'h0000_0000;
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNMAPPED = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] LAST_UNMAPPED  = {CFG_INDEX_W{1'b1}};
    localparam int RANDOM_PHASES   = 14;
    localparam int PHASE_ELEMENTS  = 92;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_PHASE      = 3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   item_valid;
    logic                   item_ready;
    in_beat_t               item;
    logic                   result_valid;
    logic                   result_ready;
    out_beat_t              result;

    int pending_count;
    int fail_count;
    int element_count;
    int vector_count;

    int burst_left;
    int vector_left;
    int setting_count;
    bit hold_req;
    bit hold_done;

    complex_dot_axpy_stream i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    complex_dot_axpy_stream_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .pending_count (pending_count),
        .fail_count    (fail_count),
        .element_count (element_count),
        .vector_count  (vector_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("[complex_dot_axpy_stream] ERROR");
        $finish;
    end

    // Mostly extremes and small values, the rest fully random
    function automatic logic [FIELD_W-1:0] pick_component();
        logic [FIELD_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = Q_MAX;
            1: v = Q_MIN;
            2: v = Q_ZERO;
            3: v = '1;
            4, 5:
            begin
                v = $urandom_range(0, 4 * 65536);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic in_beat_t make_elem(input logic [FIELD_W-1:0] xr, xi, yr, yi, zr, zi,
                                           input logic last);
        in_beat_t b;
        b.x_re    = xr;
        b.x_im    = xi;
        b.y_re    = yr;
        b.y_im    = yi;
        b.z_re    = zr;
        b.z_im    = zi;
        b.last_in = last;
        return b;
    endfunction

    // One register write, one cycle of write enable
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Full register set; flag words carry junk above bit 0, plus one unmapped write
    task automatic apply_setting(input logic [FIELD_W-1:0] ar, ai, input cfg_flags_t f);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        write_reg(REG_ALPHA_REAL, ar);
        write_reg(REG_ALPHA_IMAG, ai);
        write_reg(REG_CONJ_X_AXPY, {junk[CFG_DATA_W-1:1], f.conj_x_axpy});
        junk = $urandom;
        write_reg(REG_CONJ_X_DOT, {junk[CFG_DATA_W-1:1], f.conj_x_dot});
        junk = $urandom;
        write_reg(REG_CONJ_Y_DOT, {junk[CFG_DATA_W-1:1], f.conj_y_dot});
        write_reg(CFG_INDEX_W'($urandom_range(FIRST_UNMAPPED, LAST_UNMAPPED)), $urandom);
        setting_count++;
    endtask

    // Offer one beat; the sender runs in bursts separated by gaps
    task automatic send_elem(input in_beat_t b);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        item_valid = 1'b1;
        item       = b;
        burst_left--;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // Stop offering and let every outstanding beat come back
    task automatic settle();
        @(negedge clk);
        item_valid = 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [FIELD_W-1:0] pick_alpha();
        case ($urandom_range(0, 6))
            0: return Q_ZERO;
            1: return Q_MAX;
            2: return Q_MIN;
            3: return Q_ONE;
            4: return -Q_ONE;
            5: return FIELD_W'($urandom_range(0, 8 * 65536)) - FIELD_W'(4 * 65536);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: stretches of different stall patterns, one long hold-off on request
    initial
    begin
        int mode;
        int len;
        result_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            repeat (len)
            begin
                @(negedge clk);
                if (hold_req && !hold_done)
                begin
                    result_ready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: result_ready = 1'b1;
                    1: result_ready = $urandom_range(0, 1);
                    2: result_ready = ($urandom_range(0, 3) == 0);
                    default: result_ready = ~result_ready;
                endcase
            end
        end
    end

    // Stimulus
    initial
    begin
        cfg_flags_t f;
        logic       last;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ALPHA_REAL;
        cfg_data      = '0;
        item_valid    = 1'b0;
        item          = '0;
        burst_left    = 0;
        vector_left   = 0;
        setting_count = 0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: alpha zero, so z passes through
        send_elem(make_elem(Q_MAX, Q_MIN, Q_ONE, Q_ONE, Q_MAX, Q_MIN, 1'b0));
        send_elem(make_elem(Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_ZERO, Q_ONE, 1'b1));
        settle();

        // alpha at the extremes, z driven into both saturation rails
        f = '0;
        apply_setting(Q_MAX, Q_MIN, f);
        send_elem(make_elem(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
        send_elem(make_elem(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
        send_elem(make_elem(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0));
        send_elem(make_elem(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1));
        send_elem(make_elem(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 1'b1));
        send_elem(make_elem('1, '1, '1, '1, '1, '1, 1'b0));
        send_elem(make_elem(Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ZERO, Q_ZERO, 1'b0));
        settle();

        // all conjugations on; vector left open across the change
        f = '1;
        apply_setting(Q_MIN, Q_MAX, f);
        send_elem(make_elem(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0));
        send_elem(make_elem(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0));
        send_elem(make_elem(Q_ONE, Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1));
        send_elem(make_elem(Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_ZERO, Q_ZERO, 1'b1));
        settle();

        // fractional alpha, mixed conjugation
        f.conj_x_axpy = 1'b1;
        f.conj_x_dot  = 1'b0;
        f.conj_y_dot  = 1'b1;
        apply_setting(-Q_ONE, 32'h0000_8001, f);
        send_elem(make_elem(32'h0000_0001, 32'hFFFF_FFFF, Q_ONE, -Q_ONE, Q_ZERO, Q_ZERO, 1'b0));
        send_elem(make_elem(32'h0001_7FFF, 32'hFFFE_8001, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0));
        send_elem(make_elem(Q_MIN, Q_MAX, Q_ONE, Q_ONE, Q_MIN, Q_MAX, 1'b1));
        settle();

        // random phases; vectors run on across setting changes
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 8)
                f = cfg_flags_t'(phase[2:0]);
            else
                f = cfg_flags_t'(3'($urandom_range(0, 7)));
            apply_setting(pick_alpha(), pick_alpha(), f);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ELEMENTS; n++)
            begin
                if (vector_left == 0)
                    vector_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                              : $urandom_range(1, 12);
                vector_left--;
                last = (vector_left == 0);
                send_elem(make_elem(pick_component(), pick_component(), pick_component(),
                                    pick_component(), pick_component(), pick_component(),
                                    last));
            end
            settle();
        end

        // close any open vector so its sum is checked too
        send_elem(make_elem(pick_component(), pick_component(), pick_component(),
                            pick_component(), pick_component(), pick_component(), 1'b1));
        settle();
        repeat (10) @(posedge clk);

        $display("Covered %0d elements in %0d closed vectors across %0d register settings,",
                 element_count, vector_count, setting_count);
        $display("including a %0d-cycle output hold-off with the input back-pressured.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("[complex_dot_axpy_stream] OK");
        else
            $display("[complex_dot_axpy_stream] ERROR");
        $finish;
    end

endmodule
